/* hw/rtl/cosine_similarity_stream_assert.svh */
// assertion macros for the cosine similarity stream block
// used by the top level only, no other dependencies
`ifndef COSINE_SIMILARITY_STREAM_ASSERT_SVH
`define COSINE_SIMILARITY_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSS_ASSERT_IMPL(label, clk, rst_n, cond)
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/cossim_pkg.sv */
// shared types and constants for the cosine similarity stream block
// no dependencies
package cossim_pkg;
  localparam int unsigned ElemBits    = 16;
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned OutFracBits = 14;
  localparam int unsigned SimBits     = 16;
  localparam int unsigned CntBits     = $clog2(MaxElements) + 1;
  localparam int unsigned NormBits    = 2 * ElemBits - 2 + CntBits;
  localparam int unsigned DotBits     = NormBits + 1;
  localparam int unsigned QBits       = OutFracBits + 1;
  localparam int unsigned QIdxBits    = $clog2(QBits);
  localparam int unsigned ProdBits    = 2 * QBits + 2 * NormBits;
  localparam int unsigned MulSteps    = (NormBits > 2 * QBits) ? NormBits : 2 * QBits;
  localparam int unsigned StepBits    = $clog2(MulSteps + 1);
  localparam logic [NormBits-1:0] Lim =
    NormBits'(MaxElements) << (2 * ElemBits - 2);

  typedef struct packed {
    logic [NormBits-1:0] dot_mag;
    logic                dot_neg;
    logic [NormBits-1:0] norm_a;
    logic [NormBits-1:0] norm_b;
    logic                sat;
  } vec_sums_t;

  typedef struct packed {
    logic signed [SimBits-1:0] similarity;
    logic                      zero_norm;
    logic                      overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_LOAD, ST_MUL2, ST_CMP, ST_OUT
  } back_state_e;
endpackage

/* hw/rtl/cossim_if.sv */
// valid/ready stream interfaces for element and result words
// depends on cossim_pkg
interface cossim_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cossim_pkg::ElemBits-1:0] elem_a;
  logic signed [cossim_pkg::ElemBits-1:0] elem_b;
  logic                                    last;
  modport source (output valid, elem_a, elem_b, last, input ready);
  modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

interface cossim_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cossim_pkg::SimBits-1:0] similarity;
  logic                                   zero_norm;
  logic                                   overflow;
  modport source (output valid, similarity, zero_norm, overflow, input ready);
  modport sink (input valid, similarity, zero_norm, overflow, output ready);
endinterface

/* hw/rtl/cosine_similarity_stream.sv */
// cosine similarity stream: one element word per cycle, result per vector; the
// result comes from serial shift-add products and a bit-serial quotient search,
// both skipped when a norm is zero; one word per cycle while the two-vector queue
// has room; the back end takes a vector only when idle, so short vectors stall
// the input; reset: async active low clears sums, queue, state and result valid;
// depends on cossim_pkg, cossim_if, cossim_front, cossim_back and the assert header
`include "cosine_similarity_stream_assert.svh"
module cosine_similarity_stream (
  input logic         clk_i,
  input logic         rst_ni,
  cossim_in_if.sink    in_if,
  cossim_out_if.source out_if
);
  logic sums_valid, sums_ready;
  cossim_pkg::vec_sums_t sums;
  cossim_pkg::result_t res;

  cossim_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_if.valid), .ready_o(in_if.ready),
    .elem_a_i(in_if.elem_a), .elem_b_i(in_if.elem_b), .last_i(in_if.last),
    .sums_valid_o(sums_valid), .sums_ready_i(sums_ready), .sums_o(sums)
  );

  cossim_back u_back (
    .clk_i, .rst_ni,
    .sums_valid_i(sums_valid), .sums_ready_o(sums_ready), .sums_i(sums),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.similarity = res.similarity;
  assign out_if.zero_norm = res.zero_norm;
  assign out_if.overflow = res.overflow;

  `CSS_ASSERT_IMPL(a_zero_sim, clk_i, rst_ni, !out_if.valid || !out_if.zero_norm || out_if.similarity == '0)
  `CSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.similarity))
endmodule

/* hw/rtl/cossim_front.sv */
// front end: accumulates dot product and norms per element word
// hands finished vector sums to a two-entry queue; depends on cossim_pkg
module cossim_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic signed [cossim_pkg::ElemBits-1:0] elem_a_i,
  input  logic signed [cossim_pkg::ElemBits-1:0] elem_b_i,
  input  logic                                    last_i,
  output logic                                    sums_valid_o,
  input  logic                                    sums_ready_i,
  output cossim_pkg::vec_sums_t                   sums_o
);
  localparam int unsigned NB = cossim_pkg::NormBits;
  localparam int unsigned DB = cossim_pkg::DotBits;
  localparam int unsigned PB = 2 * cossim_pkg::ElemBits;

  logic signed [DB-1:0] dot_q, dot_d;
  logic [NB-1:0] na_q, na_d, nb_q, nb_d;
  logic sat_q, sat_d;
  logic signed [PB-1:0] pab, paa, pbb;
  logic signed [DB+1:0] dsum, lim_s;
  logic [NB:0] asum, bsum;
  logic take;
  cossim_pkg::vec_sums_t fifo_q [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  cossim_pkg::vec_sums_t push;

  assign ready_o = (cnt_q != 2'd2);
  assign take = valid_i && ready_o;
  assign pab = PB'(elem_a_i) * PB'(elem_b_i);
  assign paa = PB'(elem_a_i) * PB'(elem_a_i);
  assign pbb = PB'(elem_b_i) * PB'(elem_b_i);
  assign lim_s = (DB + 2)'(cossim_pkg::Lim);
  assign dsum = (DB + 2)'(dot_q) + (DB + 2)'(pab);
  assign asum = {1'b0, na_q} + (NB + 1)'(unsigned'(paa));
  assign bsum = {1'b0, nb_q} + (NB + 1)'(unsigned'(pbb));

  always_comb begin
    sat_d = sat_q;
    dot_d = DB'(dsum);
    if (dsum > lim_s) begin
      dot_d = DB'(lim_s);
      sat_d = 1'b1;
    end else if (dsum < -lim_s) begin
      dot_d = DB'(-lim_s);
      sat_d = 1'b1;
    end
    na_d = NB'(asum);
    if (asum > (NB + 1)'(cossim_pkg::Lim)) begin
      na_d = cossim_pkg::Lim;
      sat_d = 1'b1;
    end
    nb_d = NB'(bsum);
    if (bsum > (NB + 1)'(cossim_pkg::Lim)) begin
      nb_d = cossim_pkg::Lim;
      sat_d = 1'b1;
    end
    push.dot_neg = dot_d[DB-1];
    push.dot_mag = dot_d[DB-1] ? NB'(-dot_d) : NB'(dot_d);
    push.norm_a = na_d;
    push.norm_b = nb_d;
    push.sat = sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q <= '0;
      nb_q <= '0;
      sat_q <= 1'b0;
    end else if (take) begin
      if (last_i) begin
        dot_q <= '0;
        na_q <= '0;
        nb_q <= '0;
        sat_q <= 1'b0;
      end else begin
        dot_q <= dot_d;
        na_q <= na_d;
        nb_q <= nb_d;
        sat_q <= sat_d;
      end
    end
  end

  // two-entry queue of vector sums
  logic push_en, pop_en;
  assign push_en = take && last_i;
  assign pop_en = sums_valid_o && sums_ready_i;
  assign sums_valid_o = (cnt_q != 2'd0);
  assign sums_o = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      if (push_en) wr_q <= ~wr_q;
      if (pop_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_en} - {1'b0, pop_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) fifo_q[wr_q] <= push;
  end
endmodule

/* hw/rtl/cossim_back.sv */
// back end: shift-add products, then bit-serial search for q with
// q^2*na*nb <= dot^2*2^(2F), one candidate bit per pass; depends on cossim_pkg
module cossim_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sums_valid_i,
  output logic                  sums_ready_o,
  input  cossim_pkg::vec_sums_t sums_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output cossim_pkg::result_t   res_o
);
  localparam int unsigned NB = cossim_pkg::NormBits;
  localparam int unsigned QB = cossim_pkg::QBits;
  localparam int unsigned FB = cossim_pkg::OutFracBits;
  localparam int unsigned XB = cossim_pkg::ProdBits;
  localparam int unsigned IB = cossim_pkg::QIdxBits;
  localparam int unsigned SB = cossim_pkg::StepBits;

  cossim_pkg::back_state_e state_q, state_d;
  cossim_pkg::vec_sums_t s_q;
  logic [2*NB-1:0] nn_q, dd_q, na_sh_q, dm_sh_q;
  logic [NB-1:0] nb_sh_q, dm_bits_q;
  logic [XB-1:0] lhs_q, xa_q;
  logic [2*QB-1:0] cc_q;
  logic [QB-1:0] q_q, cand_q;
  logic [IB-1:0] bit_q;
  logic [SB-1:0] step_q;
  logic res_v_q;
  cossim_pkg::result_t res_q;
  logic [QB-1:0] next_cand;
  logic [QB-1:0] q_new;
  logic [XB-1:0] rhs;
  logic fits, zero_in, last_step;

  assign sums_ready_o = (state_q == cossim_pkg::ST_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o = res_q;
  assign rhs = XB'(dd_q) << (2 * FB);
  assign fits = (cand_q <= (QB'(1) << FB));
  assign q_new = (fits && lhs_q <= rhs) ? cand_q : q_q;
  assign zero_in = (sums_i.norm_a == '0 || sums_i.norm_b == '0);
  assign last_step = (step_q == SB'(1));

  always_comb begin
    next_cand = q_new | (QB'(1) << (bit_q - IB'(1)));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cossim_pkg::ST_IDLE: begin
        if (sums_valid_i) state_d = zero_in ? cossim_pkg::ST_OUT : cossim_pkg::ST_MUL1;
      end
      cossim_pkg::ST_MUL1: if (last_step) state_d = cossim_pkg::ST_LOAD;
      cossim_pkg::ST_LOAD: state_d = cossim_pkg::ST_MUL2;
      cossim_pkg::ST_MUL2: if (last_step) state_d = cossim_pkg::ST_CMP;
      cossim_pkg::ST_CMP: begin
        state_d = (bit_q == '0) ? cossim_pkg::ST_OUT : cossim_pkg::ST_LOAD;
      end
      cossim_pkg::ST_OUT:  if (!res_v_q || res_ready_i) state_d = cossim_pkg::ST_IDLE;
      default:             state_d = cossim_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cossim_pkg::ST_IDLE;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      if (state_q == cossim_pkg::ST_OUT && (!res_v_q || res_ready_i)) res_v_q <= 1'b1;
    end
  end

  // candidate starts at 2^F which is the top allowed value
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cossim_pkg::ST_IDLE: begin
        if (sums_valid_i) begin
          s_q <= sums_i;
          q_q <= '0;
          cand_q <= QB'(1) << FB;
          bit_q <= IB'(FB);
          na_sh_q <= (2*NB)'(sums_i.norm_a);
          nb_sh_q <= sums_i.norm_b;
          dm_sh_q <= (2*NB)'(sums_i.dot_mag);
          dm_bits_q <= sums_i.dot_mag;
          nn_q <= '0;
          dd_q <= '0;
          step_q <= SB'(NB);
        end
      end
      cossim_pkg::ST_MUL1: begin
        if (nb_sh_q[0]) nn_q <= nn_q + na_sh_q;
        if (dm_bits_q[0]) dd_q <= dd_q + dm_sh_q;
        na_sh_q <= na_sh_q << 1;
        nb_sh_q <= nb_sh_q >> 1;
        dm_sh_q <= dm_sh_q << 1;
        dm_bits_q <= dm_bits_q >> 1;
        step_q <= step_q - SB'(1);
      end
      cossim_pkg::ST_LOAD: begin
        xa_q <= XB'(nn_q);
        cc_q <= (2*QB)'(cand_q) * (2*QB)'(cand_q);
        lhs_q <= '0;
        step_q <= SB'(2 * QB);
      end
      cossim_pkg::ST_MUL2: begin
        if (cc_q[0]) lhs_q <= lhs_q + xa_q;
        xa_q <= xa_q << 1;
        cc_q <= cc_q >> 1;
        step_q <= step_q - SB'(1);
      end
      cossim_pkg::ST_CMP: begin
        q_q <= q_new;
        if (bit_q != '0) begin
          cand_q <= next_cand;
          bit_q <= bit_q - IB'(1);
        end
      end
      cossim_pkg::ST_OUT: begin
        if (!res_v_q || res_ready_i) begin
          res_q.zero_norm <= (s_q.norm_a == '0 || s_q.norm_b == '0);
          res_q.overflow <= s_q.sat;
          if (s_q.norm_a == '0 || s_q.norm_b == '0)
            res_q.similarity <= '0;
          else if (s_q.dot_neg)
            res_q.similarity <= cossim_pkg::SimBits'(-q_q);
          else
            res_q.similarity <= cossim_pkg::SimBits'(q_q);
        end
      end
      default: ;
    endcase
  end
endmodule

/* verif/cosine_similarity_stream_test.sv */
// testbench for cosine_similarity_stream: directed and random element words, bit-exact predictor
// depends on cossim_pkg, cossim_if and the block under test
`timescale 1ns / 100ps
module cosine_similarity_stream_test;
  localparam int unsigned EB = cossim_pkg::ElemBits;
  localparam int unsigned SB = cossim_pkg::SimBits;
  localparam int unsigned FB = cossim_pkg::OutFracBits;
  localparam int unsigned ME = cossim_pkg::MaxElements;

  typedef struct {
    logic signed [EB-1:0] elem_a;
    logic signed [EB-1:0] elem_b;
    logic                 last;
  } pair_t;

  typedef struct {
    logic signed [SB-1:0] similarity;
    logic                 zero_norm;
    logic                 overflow;
  } cos_t;

  localparam longint LimVal = longint'(ME) << (2 * EB - 2);
  localparam int unsigned CycleLimit = 5000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cossim_in_if  in_if ();
  cossim_out_if out_if ();

  cosine_similarity_stream u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  pair_t  pending_words[$];
  cos_t   expected_cos[$];
  longint dot_acc, norm_a_acc, norm_b_acc;
  bit     clamped;
  int     errors;
  int     cycles;
  bit     stim_done;
  bit     hold_long;
  bit     in_acc;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v > hi) begin
      clamped = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clamped = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // exact truncated cosine: largest q <= 1.0 with q^2*na*nb <= dot^2*2^2F
  function automatic void predict_cosine(pair_t p);
    longint a, b, dmag;
    logic [255:0] rhs, nn, lhs, q, cand;
    cos_t r;
    a = longint'(p.elem_a);
    b = longint'(p.elem_b);
    dot_acc    = clamp_to(dot_acc + a * b, -LimVal, LimVal);
    norm_a_acc = clamp_to(norm_a_acc + a * a, 0, LimVal);
    norm_b_acc = clamp_to(norm_b_acc + b * b, 0, LimVal);
    if (!p.last) return;
    r.similarity = '0;
    r.zero_norm  = 1'b0;
    if (norm_a_acc == 0 || norm_b_acc == 0) begin
      r.zero_norm = 1'b1;
    end else begin
      dmag = dot_acc < 0 ? -dot_acc : dot_acc;
      rhs = (256'(dmag) * 256'(dmag)) << (2 * FB);
      nn  = 256'(norm_a_acc) * 256'(norm_b_acc);
      q = '0;
      for (int bit_i = FB; bit_i >= 0; bit_i--) begin
        cand = q | (256'(1) << bit_i);
        if (cand > (256'(1) << FB)) continue;
        lhs = cand * cand * nn;
        if (lhs <= rhs) q = cand;
      end
      r.similarity = dot_acc < 0 ? SB'(-q) : SB'(q);
    end
    r.overflow = clamped;
    expected_cos.insert(expected_cos.size(), r);
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    clamped = 1'b0;
  endfunction

  function automatic void add_word(logic [EB-1:0] a, logic [EB-1:0] b, logic l);
    pair_t p;
    p.elem_a = a;
    p.elem_b = b;
    p.last   = l;
    pending_words.insert(pending_words.size(), p);
  endfunction

  function automatic logic [EB-1:0] rand_elem(int mode);
    case (mode)
      0: return EB'($urandom);
      1: return EB'($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      2: return EB'($urandom_range(0, 15) - 8);
      default: return EB'($urandom_range(0, 2) == 0 ? 0 : $urandom);
    endcase
  endfunction

  initial begin
    int total, len, mode;
    // directed vectors
    add_word(16'h7fff, 16'h7fff, 1'b1);
    add_word(16'h8000, 16'h8000, 1'b1);
    add_word(16'h7fff, 16'h8000, 1'b1);
    add_word(16'h0000, 16'h1234, 1'b1);
    add_word(16'h4321, 16'h0000, 1'b1);
    add_word(16'h0000, 16'h0000, 1'b1);
    add_word(16'h0001, 16'h0000, 1'b0);
    add_word(16'h0000, 16'h0001, 1'b1);
    add_word(16'h0003, 16'h0004, 1'b0);
    add_word(16'h0004, 16'hfffd, 1'b1);
    add_word(16'hffff, 16'h0001, 1'b0);
    add_word(16'h5555, 16'haaaa, 1'b0);
    add_word(16'h7ffe, 16'h0123, 1'b1);
    // a saturating vector at full scale, clamping on its last word
    for (int i = 0; i < ME + 1; i++)
      add_word(16'h8000, 16'h7fff, i == ME);
    total = pending_words.size();
    while (total < 1300) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        add_word(rand_elem(mode), rand_elem(mode), i == len - 1);
      total += len;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // sender: bursts with gaps
  int burst_left, gap_left;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.elem_a <= '0;
      in_if.elem_b <= '0;
      in_if.last   <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
      stim_done    <= 1'b0;
    end else if (!(in_if.valid && !in_acc)) begin
      if (in_acc) void'(pending_words.pop_front());
      if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_if.valid <= 1'b0;
        stim_done   <= 1'b1;
      end else begin
        in_if.valid  <= 1'b1;
        in_if.elem_a <= pending_words[0].elem_a;
        in_if.elem_b <= pending_words[0].elem_b;
        in_if.last   <= pending_words[0].last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
          gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    pair_t p;
    in_acc <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      p.elem_a = in_if.elem_a;
      p.elem_b = in_if.elem_b;
      p.last   = in_if.last;
      predict_cosine(p);
    end
  end

  // long hold-off once, early in the run
  int hold_count;
  initial begin
    hold_long = 1'b0;
    hold_count = 0;
    @(posedge rst_ni);
    repeat (40) @(posedge clk_i);
    hold_long = 1'b1;
    while (hold_count < 3000) begin
      @(posedge clk_i);
      hold_count++;
    end
    hold_long = 1'b0;
  end

  // receiver stall pattern
  int stall_phase;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_long) out_if.ready <= 1'b0;
      else if (stall_phase[9]) out_if.ready <= 1'b1;
      else out_if.ready <= $urandom_range(0, 3) != 0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cos_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_cos.size() == 0) begin
        $display("%0t: unexpected result sim %0d zn %0b ovf %0b", $time,
                 out_if.similarity, out_if.zero_norm, out_if.overflow);
        errors++;
      end else begin
        e = expected_cos.pop_front();
        if (out_if.similarity !== e.similarity) begin
          $display("%0t: similarity expected %0d actual %0d", $time, e.similarity,
                   out_if.similarity);
          errors++;
        end
        if (out_if.zero_norm !== e.zero_norm) begin
          $display("%0t: zero_norm expected %0b actual %0b", $time, e.zero_norm,
                   out_if.zero_norm);
          errors++;
        end
        if (out_if.overflow !== e.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time, e.overflow,
                   out_if.overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    clamped = 1'b0;
    @(posedge rst_ni);
    while (!(stim_done && expected_cos.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("cosine_similarity_stream_test: done, errors");
    end else begin
      repeat (200) @(posedge clk_i);
      if (errors == 0) begin
        $display("cosine_similarity_stream_test: done, clean");
      end else begin
        $display("cosine_similarity_stream_test: done, errors");
      end
    end
    $finish;
  end
endmodule
